### hw/rtl/sorted_array_priority_queue_defines.svh
// Assertion macros shared by the checker of the sorted array priority queue.
// Depends on nothing; included by the checker file by its bare name.
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define SAPQ_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define SAPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/sapq_pkg.sv
// Package of the sorted array priority queue: field widths, codes and the entry type.
// Depends on nothing; used by the top level and the checker.
package sapq_pkg;

  localparam int unsigned DepthDefault = 8;
  localparam int unsigned ValueW       = 32;
  localparam int unsigned RankW        = 32;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned FillW        = 4;

  // Request codes.
  localparam logic ReqInsert = 1'b0;
  localparam logic ReqRemove = 1'b1;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // One stored entry, rank in the upper half.
  typedef struct packed {
    logic signed [RankW-1:0]  rank;
    logic signed [ValueW-1:0] value;
  } entry_t;

endpackage

### hw/rtl/sapq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module sapq_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/sorted_array_priority_queue.sv
// Sorted array priority queue: one request at a time, busy from acceptance to result.
// Insert moves each held entry ranked after the new one up a slot, then writes the new
// entry; remove reads the head, then copies each following entry one slot down.
// The entry RAM has one write port and one read port with a registered read, so each
// move waits for its read. The result strobe lasts one cycle as busy falls.
// Reset (rst_ni low, asynchronous) empties the queue; the RAM itself is not cleared.
module sorted_array_priority_queue #(
  parameter int unsigned DEPTH = sapq_pkg::DepthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                req_type_i,
  input  logic signed [sapq_pkg::ValueW-1:0]  item_value_i,
  input  logic signed [sapq_pkg::RankW-1:0]   item_rank_i,
  output logic                                done_o,
  output logic        [sapq_pkg::StatusW-1:0] status_o,
  output logic signed [sapq_pkg::ValueW-1:0]  out_value_o,
  output logic signed [sapq_pkg::RankW-1:0]   out_rank_o,
  output logic        [sapq_pkg::FillW-1:0]   fill_count_o
);

  import sapq_pkg::*;

  // Address width indexes a slot; count width also holds DEPTH itself.
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // The sequencer. Insert walks from the tail toward the head, reading the entry
  // just below the free slot and moving it up while its rank is greater than the
  // new rank. Remove reads the head, then copies each following entry one slot down.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REJECT,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_REM_HEAD,
    ST_REM_RD,
    ST_REM_WR
  } state_e;

  state_e            state_q;
  logic [CW-1:0]     occ_q;
  logic [CW-1:0]     idx_q;
  entry_t            new_q;
  logic              done_q;
  status_e           status_q;
  logic [ValueW-1:0] out_value_q;
  logic [RankW-1:0]  out_rank_q;

  // RAM ports.
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  entry_t          ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t          rd_entry;

  logic [CW-1:0] idx_dec;
  logic [CW-1:0] idx_inc;
  logic          rank_above;
  logic          last_move;

  assign rd_entry = entry_t'(ram_rdata);
  assign idx_dec  = idx_q - CW'(1);
  assign idx_inc  = idx_q + CW'(1);

  // The insert compare: is the entry just read ranked after the new one?
  assign rank_above = rd_entry.rank > new_q.rank;

  // The remove loop ends once the slot just written is the second to last held one.
  assign last_move = ({1'b0, idx_q} + (CW + 1)'(2)) == {1'b0, occ_q};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q[AW-1:0];
    ram_wdata = new_q;
    ram_raddr = '0;
    case (state_q)
      ST_INS_RD: begin
        ram_raddr = idx_dec[AW-1:0];
      end
      ST_INS_CMP: begin
        ram_we = 1'b1;
        if (rank_above) begin
          ram_wdata = rd_entry;
        end
      end
      ST_INS_PUT: begin
        ram_we = 1'b1;
      end
      ST_REM_RD: begin
        ram_raddr = idx_inc[AW-1:0];
      end
      ST_REM_WR: begin
        ram_we    = 1'b1;
        ram_wdata = rd_entry;
      end
      default: begin
        ram_raddr = '0;
      end
    endcase
  end

  sapq_ram #(
    .Width($bits(entry_t)),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // State, occupancy and the result registers. A result is set up while the
  // sequencer works and shown for one cycle as it returns to idle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      idx_q       <= '0;
      done_q      <= 1'b0;
      status_q    <= STATUS_OK;
      new_q       <= '0;
      out_value_q <= '0;
      out_rank_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            new_q.value <= item_value_i;
            new_q.rank  <= item_rank_i;
            out_value_q <= '0;
            out_rank_q  <= '0;
            status_q    <= STATUS_OK;
            if (req_type_i == ReqInsert) begin
              if (occ_q == CW'(DEPTH)) begin
                status_q <= STATUS_FULL;
                state_q  <= ST_REJECT;
              end else if (occ_q == '0) begin
                idx_q   <= '0;
                state_q <= ST_INS_PUT;
              end else begin
                idx_q   <= occ_q;
                state_q <= ST_INS_RD;
              end
            end else begin
              if (occ_q == '0) begin
                status_q <= STATUS_EMPTY;
                state_q  <= ST_REJECT;
              end else begin
                // The head read address is presented while idle.
                state_q <= ST_REM_HEAD;
              end
            end
          end
        end
        ST_REJECT: begin
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        ST_INS_RD: begin
          state_q <= ST_INS_CMP;
        end
        ST_INS_CMP: begin
          if (rank_above) begin
            idx_q <= idx_dec;
            if (idx_q == CW'(1)) begin
              state_q <= ST_INS_PUT;
            end else begin
              state_q <= ST_INS_RD;
            end
          end else begin
            occ_q   <= occ_q + CW'(1);
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        ST_INS_PUT: begin
          occ_q   <= occ_q + CW'(1);
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        ST_REM_HEAD: begin
          out_value_q <= rd_entry.value;
          out_rank_q  <= rd_entry.rank;
          idx_q       <= '0;
          if (occ_q == CW'(1)) begin
            occ_q   <= occ_q - CW'(1);
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_REM_RD;
          end
        end
        ST_REM_RD: begin
          state_q <= ST_REM_WR;
        end
        ST_REM_WR: begin
          idx_q <= idx_inc;
          if (last_move) begin
            occ_q   <= occ_q - CW'(1);
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_REM_RD;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy         = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign out_value_o  = out_value_q;
  assign out_rank_o   = out_rank_q;
  assign fill_count_o = FillW'(occ_q);

endmodule

### hw/rtl/sapq_checker.sv
// Port-level checker of the sorted array priority queue, bound to the top level.
// Depends on sapq_pkg and sorted_array_priority_queue_defines.svh.
`include "sorted_array_priority_queue_defines.svh"

module sapq_checker #(
  parameter int unsigned DEPTH = sapq_pkg::DepthDefault
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic                                done_o,
  input logic        [sapq_pkg::StatusW-1:0] status_o,
  input logic signed [sapq_pkg::ValueW-1:0]  out_value_o,
  input logic signed [sapq_pkg::RankW-1:0]   out_rank_o,
  input logic        [sapq_pkg::FillW-1:0]   fill_count_o
);

  import sapq_pkg::*;

  // Every accepted item makes the block busy in the next cycle.
  `SAPQ_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "accept without busy")

  // A result appears only once the block has gone idle.
  `SAPQ_ASSERT_NOW(a_done_idle, clk_i, rst_ni, done_o, !busy, "result while busy")

  // One result per item: no two strobes in a row.
  `SAPQ_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o, "repeated result")

  // A refused insert reports a full queue and no data.
  `SAPQ_ASSERT_NOW(a_full_result, clk_i, rst_ni, done_o && (status_o == STATUS_FULL),
    (fill_count_o == FillW'(DEPTH)) && (out_value_o == '0) && (out_rank_o == '0),
    "bad full result")

  // A refused remove reports an empty queue and no data.
  `SAPQ_ASSERT_NOW(a_empty_result, clk_i, rst_ni, done_o && (status_o == STATUS_EMPTY),
    (fill_count_o == '0) && (out_value_o == '0) && (out_rank_o == '0),
    "bad empty result")

endmodule

bind sorted_array_priority_queue sapq_checker #(
  .DEPTH(DEPTH)
) u_sapq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .status_o     (status_o),
  .out_value_o  (out_value_o),
  .out_rank_o   (out_rank_o),
  .fill_count_o (fill_count_o)
);
